/* rtl/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared constants and types for the fully associative LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int ENTRIES     = 16;
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W       = $clog2(ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int DATA_W      = 32;
  localparam int CAP_RESET   = 16;

  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_PUT = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                     kind;
    logic signed [DATA_W-1:0]  key;
    logic signed [DATA_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic                      hit;
    logic signed [DATA_W-1:0]  read_value;
    logic                      evicted;
    logic signed [DATA_W-1:0]  evicted_key;
  } res_t;

endpackage

/* rtl/lkvc_core.sv */
// ----------------------------------------------------------------------------
// lkvc_core
// Entry table, parallel key match, recency ranks and replacement choice.
// Computes the result of one request and updates the table on fire_i.
// ----------------------------------------------------------------------------
module lkvc_core import lkvc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CAP_W-1:0] capacity_i,
  input  logic             fire_i,
  input  req_t             req_i,
  output res_t             res_o
);

  logic signed [DATA_W-1:0] key_q   [ENTRIES];
  logic signed [DATA_W-1:0] value_q [ENTRIES];
  logic [ENTRIES-1:0]       valid_q;
  logic [IDX_W-1:0]         rank_q  [ENTRIES];
  logic [OCC_W-1:0]         occ_q;

  logic [OCC_W-1:0] cap_eff;
  logic             present;
  logic [IDX_W-1:0] found;
  logic [IDX_W-1:0] free_slot;
  logic [IDX_W-1:0] victim;
  logic             is_put;
  logic             full;
  logic             touch;
  logic             do_fill;
  logic             do_key_wr;
  logic             do_val_wr;
  logic [IDX_W-1:0] slot;
  logic [OCC_W-1:0] old_rank;

  always_comb begin
    if (capacity_i == '0) begin
      cap_eff = OCC_W'(1);
    end else if (int'(capacity_i) > ENTRIES) begin
      cap_eff = OCC_W'(ENTRIES);
    end else begin
      cap_eff = OCC_W'(capacity_i);
    end
  end

  // key match, first free slot, least recent slot
  always_comb begin
    present   = 1'b0;
    found     = '0;
    free_slot = '0;
    victim    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_q[i] && (key_q[i] == req_i.key)) begin
        present = 1'b1;
        found   = IDX_W'(i);
      end
      if (valid_q[i] && (OCC_W'(rank_q[i]) == (occ_q - OCC_W'(1)))) begin
        victim = IDX_W'(i);
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = IDX_W'(i);
      end
    end
  end

  always_comb begin
    is_put    = (req_i.kind == KIND_PUT);
    full      = (occ_q >= cap_eff);
    touch     = fire_i && (present || is_put);
    do_key_wr = fire_i && is_put && !present;
    do_fill   = do_key_wr && !full;
    do_val_wr = fire_i && is_put;
    if (present) begin
      slot     = found;
      old_rank = OCC_W'(rank_q[found]);
    end else if (full) begin
      slot     = victim;
      old_rank = occ_q - OCC_W'(1);
    end else begin
      slot     = free_slot;
      old_rank = occ_q;
    end
  end

  always_comb begin
    res_o.hit         = present;
    res_o.read_value  = (!is_put && present) ? value_q[found] : '0;
    res_o.evicted     = is_put && !present && full;
    res_o.evicted_key = (is_put && !present && full) ? key_q[victim] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (touch) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == slot) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && (OCC_W'(rank_q[i]) < old_rank)) begin
            rank_q[i] <= rank_q[i] + IDX_W'(1);
          end
        end
      end
      if (do_fill) begin
        valid_q[slot] <= 1'b1;
        occ_q         <= occ_q + OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_key_wr) begin
      key_q[slot] <= req_i.key;
    end
    if (do_val_wr) begin
      value_q[slot] <= req_i.value;
    end
  end

`ifndef ASSERT_OFF
  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy differs from number of valid entries");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(occ_q) <= ENTRIES)
    else $error("occupancy above table depth");

  a_fill_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_fill |=> (occ_q == $past(occ_q) + OCC_W'(1)))
    else $error("fill did not grow occupancy by one");

  a_evict_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.evicted) |=> $stable(occ_q) && $stable(valid_q))
    else $error("eviction changed occupancy");

  a_hit_not_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |-> !(res_o.hit && res_o.evicted))
    else $error("hit and eviction on one request");
`endif

endmodule

/* rtl/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, kind, key, value   | request
//   out     | out_valid_o/out_ready_i, hit, read_value, | result
//           | evicted, evicted_key                      |
//   cfg     | cfg_we_i, cfg_wdata_i (capacity)          | write only
//
// One request per cycle unless results stall; a request passes the request
// register, then the result register; match and rank update share a cycle.
// Reset clears valid bits, ranks and occupancy; capacity resets to 16.
// A stalled result holds the result register; the request register keeps
// accepting as long as the result register is free or being taken.
// ----------------------------------------------------------------------------
module lru_key_value_cache import lkvc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CAP_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     in_kind_i,
  input  logic signed [DATA_W-1:0] in_key_i,
  input  logic signed [DATA_W-1:0] in_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     out_hit_o,
  output logic signed [DATA_W-1:0] out_read_value_o,
  output logic                     out_evicted_o,
  output logic signed [DATA_W-1:0] out_evicted_key_o
);

  logic [CAP_W-1:0] capacity_q;
  logic             req_valid_q;
  req_t             req_q;
  logic             res_valid_q;
  res_t             res_q;
  res_t             res_d;
  logic             res_free;
  logic             fire;

  assign res_free   = !res_valid_q || out_ready_i;
  assign fire       = req_valid_q && res_free;
  assign in_ready_o = !req_valid_q || res_free;

  lkvc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .capacity_i (capacity_q),
    .fire_i     (fire),
    .req_i      (req_q),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= CAP_W'(CAP_RESET);
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        req_valid_q <= in_valid_i;
      end
      if (res_free) begin
        res_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q.kind  <= kind_e'(in_kind_i);
      req_q.key   <= in_key_i;
      req_q.value <= in_value_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = res_valid_q;
  assign out_hit_o         = res_q.hit;
  assign out_read_value_o  = res_q.read_value;
  assign out_evicted_o     = res_q.evicted;
  assign out_evicted_key_o = res_q.evicted_key;

`ifndef ASSERT_OFF
  a_res_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !out_ready_i) |=> res_valid_q && $stable(res_q))
    else $error("stalled result changed");

  a_fire_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> res_valid_q)
    else $error("processed request left no result");

  a_no_fire_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !out_ready_i) |-> !fire)
    else $error("request processed while result stalled");
`endif

endmodule

/* dv/lru_key_value_cache_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_checker
// Watches the request, result and capacity ports of the LRU key-value cache.
// Keeps its own copy of the table and recency order, predicts one result per
// accepted request and compares each accepted result with the oldest one.
// ----------------------------------------------------------------------------
module lru_key_value_cache_checker import lkvc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CAP_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic                     in_kind_i,
  input  logic signed [DATA_W-1:0] in_key_i,
  input  logic signed [DATA_W-1:0] in_value_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic                     out_hit_i,
  input  logic signed [DATA_W-1:0] out_read_value_i,
  input  logic                     out_evicted_i,
  input  logic signed [DATA_W-1:0] out_evicted_key_i,
  output int                       outstanding_o,
  output int                       mismatches_o
);

  localparam int EXP_DEPTH = 16;
  localparam int EXP_W     = $clog2(EXP_DEPTH);

  logic [DATA_W-1:0] key_tbl [ENTRIES];
  logic [DATA_W-1:0] val_tbl [ENTRIES];
  bit                used    [ENTRIES];
  int unsigned       age     [ENTRIES];
  int unsigned       fill;
  logic [CAP_W-1:0]  cap_reg;

  res_t              exp_fifo [EXP_DEPTH];
  logic [EXP_W-1:0]  exp_wr;
  logic [EXP_W-1:0]  exp_rd;
  int                exp_count;
  res_t              want;
  int                mismatches;
  int                results_seen;

  assign mismatches_o = mismatches;

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] seen,
                             input logic [DATA_W-1:0] exp_val);
    if (seen !== exp_val)
      report_mismatch($sformatf("result %0d %s = %h, expected %h",
                                results_seen, name, seen, exp_val));
  endtask

  // slot becomes most recent; younger valid entries age by one
  function automatic void touch(int slot, int unsigned old_age);
    for (int i = 0; i < ENTRIES; i++) begin
      if (used[i] && i != slot && age[i] < old_age) age[i]++;
    end
    age[slot] = 0;
  endfunction

  function automatic res_t serve_request(kind_e kind, logic [DATA_W-1:0] key,
                                         logic [DATA_W-1:0] val);
    res_t        r;
    int unsigned lim;
    int          found;
    int          slot;
    int unsigned oldest;
    r     = '0;
    lim   = int'(cap_reg);
    if (lim < 1) lim = 1;
    if (lim > ENTRIES) lim = ENTRIES;
    found = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (used[i] && key_tbl[i] == key) found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      if (kind == KIND_GET) r.read_value = val_tbl[found];
      else val_tbl[found] = val;
      touch(found, age[found]);
    end else if (kind == KIND_PUT) begin
      slot = -1;
      if (fill >= lim) begin
        oldest = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (used[i] && (slot < 0 || age[i] > oldest)) begin
            oldest = age[i];
            slot   = i;
          end
        end
        r.evicted     = 1'b1;
        r.evicted_key = key_tbl[slot];
        key_tbl[slot] = key;
        val_tbl[slot] = val;
        touch(slot, oldest);
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !used[i]) slot = i;
        end
        used[slot]    = 1'b1;
        key_tbl[slot] = key;
        val_tbl[slot] = val;
        touch(slot, fill);
        fill++;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        used[i] = 1'b0;
        age[i]  = 0;
      end
      fill         = 0;
      cap_reg      = CAP_W'(CAP_RESET);
      results_seen = 0;
      mismatches   = 0;
      exp_wr       = '0;
      exp_rd       = '0;
      exp_count    = 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) cap_reg = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (exp_count == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want      = exp_fifo[exp_rd];
          exp_rd    = exp_rd + 1'b1;
          exp_count = exp_count - 1;
          check_field("hit", DATA_W'(out_hit_i), DATA_W'(want.hit));
          check_field("read_value", out_read_value_i, want.read_value);
          check_field("evicted", DATA_W'(out_evicted_i), DATA_W'(want.evicted));
          check_field("evicted_key", out_evicted_key_i, want.evicted_key);
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_i) begin
        if (exp_count == EXP_DEPTH) begin
          report_mismatch("too many requests outstanding");
        end else begin
          exp_fifo[exp_wr] = serve_request(kind_e'(in_kind_i), in_key_i, in_value_i);
          exp_wr           = exp_wr + 1'b1;
          exp_count        = exp_count + 1;
        end
      end
      outstanding_o <= exp_count;
    end
  end

endmodule

/* dv/tb_lru_key_value_cache.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Drives gets and puts into the LRU key-value cache over a range of capacity
// settings, with random gaps and result back-pressure; the checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;
  import lkvc_pkg::*;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CAP_W-1:0]         cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_kind;
  logic signed [DATA_W-1:0] in_key;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic                     out_hit;
  logic signed [DATA_W-1:0] out_read_value;
  logic                     out_evicted;
  logic signed [DATA_W-1:0] out_evicted_key;
  int                       outstanding;
  int                       mismatches;

  bit idle_on;
  int gap_pct;
  bit squeeze_pending;

  lru_key_value_cache dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .in_kind_i         (in_kind),
    .in_key_i          (in_key),
    .in_value_i        (in_value),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .out_hit_o         (out_hit),
    .out_read_value_o  (out_read_value),
    .out_evicted_o     (out_evicted),
    .out_evicted_key_o (out_evicted_key)
  );

  lru_key_value_cache_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .in_kind_i         (in_kind),
    .in_key_i          (in_key),
    .in_value_i        (in_value),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .out_hit_i         (out_hit),
    .out_read_value_i  (out_read_value),
    .out_evicted_i     (out_evicted),
    .out_evicted_key_i (out_evicted_key),
    .outstanding_o     (outstanding),
    .mismatches_o      (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #300000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_req(input kind_e kind, input logic [DATA_W-1:0] key,
                          input logic [DATA_W-1:0] val);
    if (idle_on && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_key   <= key;
    in_value <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  // only once the cache has drained
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // result side: random stalls, plus one long hold to back the block up
  initial begin
    out_ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (squeeze_pending) begin
        squeeze_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (120) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [CAP_W-1:0]  caps [8];
    logic [DATA_W-1:0] pool [24];
    int                pool_n;
    int                lim;
    logic [DATA_W-1:0] key;
    caps            = '{5'd1, 5'd31, 5'd4, 5'd16, 5'd0, 5'd9, 5'd2, 5'd16};
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_kind         = 1'b0;
    in_key          = '0;
    in_value        = '0;
    idle_on         = 1'b1;
    gap_pct         = 25;
    squeeze_pending = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty miss, extreme keys and values, hits, update
    send_req(KIND_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_req(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_req(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_req(KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(KIND_PUT, 32'h0000_0000, 32'h0000_0000);
    send_req(KIND_GET, 32'h8000_0000, 32'h0000_0000);
    send_req(KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_req(KIND_PUT, 32'hFFFF_FFFF, 32'h1234_5678);
    send_req(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_req(KIND_GET, 32'h0000_0001, 32'h0000_0000);
    // capacity below occupancy: one eviction per new key
    set_capacity(5'd2);
    send_req(KIND_PUT, 32'd5, 32'd5);
    send_req(KIND_PUT, 32'd6, 32'd6);
    send_req(KIND_PUT, 32'd7, 32'd7);
    send_req(KIND_GET, 32'h8000_0000, 32'h0000_0000);
    // zero capacity behaves as one
    set_capacity(5'd0);
    send_req(KIND_PUT, 32'd8, 32'd8);
    send_req(KIND_GET, 32'd7, 32'd0);
    send_req(KIND_GET, 32'd5, 32'd0);
    // above table size clamps to table size
    set_capacity(5'd31);
    send_req(KIND_PUT, 32'd9, 32'd9);

    for (int ph = 0; ph < 8; ph++) begin
      set_capacity(caps[ph]);
      lim = (caps[ph] == 0) ? 1 : (caps[ph] > ENTRIES) ? ENTRIES : caps[ph];
      pool_n = lim + $urandom_range(1, 8);
      if (pool_n > 24) pool_n = 24;
      foreach (pool[i]) pool[i] = $urandom;
      pool[0] = 32'h8000_0000;
      pool[1] = 32'h7FFF_FFFF;
      gap_pct = (ph % 3 == 2) ? 0 : 25;
      if (ph == 3) squeeze_pending = 1'b1;
      if (ph == 7) idle_on = 1'b0;
      for (int n = 0; n < 55; n++) begin
        if ($urandom_range(0, 99) < 85) key = pool[$urandom_range(0, pool_n - 1)];
        else key = $urandom;
        send_req(($urandom_range(0, 99) < 55) ? KIND_PUT : KIND_GET, key, $urandom);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (6) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
